// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TOAQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TOAQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/toaq_pkg.sv =====
// Shared types and codes of the time ordered activity queue.
`default_nettype none

package toaq_pkg;

   localparam int STAMP_W   = 32;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;

   // request kind
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // response status
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_DUE = 2'd3;

   // operation broadcast to every cell
   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_PUSH = 2'd1;
   localparam logic [1:0] OP_POP  = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [STAMP_W-1:0]   stamp;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [STAMP_W-1:0]   stamp;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, stamp: '0, payload: '0};

endpackage

`default_nettype wire

// ===== rtl/core/toaq_cell.sv =====
// One slot of the sorted shift chain.
`default_nettype none

module toaq_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire toaq_pkg::cmd_type   cmd,
   input  wire logic               prev_later,  // earlier neighbor moves back
   input  wire toaq_pkg::entry_type prev_entry,
   input  wire toaq_pkg::entry_type next_entry,
   output logic                    later,       // this slot moves back on push
   output toaq_pkg::entry_type      entry
);

   logic                           valid_ff, valid_in;
   logic [toaq_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [toaq_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;

   // empty slots always sort after the new entry; ties keep arrival order
   assign later = !valid_ff || (stamp_ff > cmd.stamp);

   always_comb begin
      valid_in   = valid_ff;
      stamp_in   = stamp_ff;
      payload_in = payload_ff;
      unique case (cmd.op)
         toaq_pkg::OP_PUSH: begin
            if (later) begin
               if (prev_later) begin
                  valid_in   = prev_entry.valid;
                  stamp_in   = prev_entry.stamp;
                  payload_in = prev_entry.payload;
               end else begin
                  valid_in   = 1'b1;
                  stamp_in   = cmd.stamp;
                  payload_in = cmd.payload;
               end
            end
         end
         toaq_pkg::OP_POP: begin
            valid_in   = next_entry.valid;
            stamp_in   = next_entry.stamp;
            payload_in = next_entry.payload;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff   <= stamp_in;
      payload_ff <= payload_in;
   end

   assign entry = '{valid: valid_ff, stamp: stamp_ff, payload: payload_ff};

endmodule

`default_nettype wire

// ===== rtl/core/time_ordered_activity_queue.sv =====
// Top level of the time ordered activity queue: cell chain and response register.
`default_nettype none
// Usage
// - req_* carries requests: req_tuser is the kind (0 push, 1 pop), req_tdata
//   the activity time, payload and the current time used by a pop.
// - rsp_* returns exactly one response per request, in request order.
//   rsp_tuser is the status (ok, full, empty, not yet due).
// - Storage is a chain of QUEUE_DEPTH cells kept sorted by time, earliest in
//   cell 0. A push is compared in every cell at once and each cell either
//   holds, takes its earlier neighbor or takes the new entry; a pop shifts
//   the whole chain toward cell 0. Equal times leave in arrival order.
// - The response is registered: it appears in the cycle after acceptance.
// - Throughput: one request per cycle while the receiver keeps up, set by
//   the compare and shift in every cell; no iteration over the stored entries.
// - The response sits in one output register. While it waits, req_tready
//   stays high only if rsp_tready is high in the same cycle; a stalled
//   receiver therefore holds off new requests after one response is pending.
// - Reset (synchronous, active high) empties the queue and drops any
//   pending response; no clearing pass is needed.
module time_ordered_activity_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] activity_time, [63:32] activity_payload, [95:64] now_time
   input  wire logic [95:0]  req_tdata,
   // [0] kind
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] released_time, [63:32] released_payload, [95:64] next_time,
   // [96] next_valid, [103:97] zero
   output logic [103:0]      rsp_tdata,
   // [1:0] status
   output logic [1:0]        rsp_tuser
);

   toaq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_later;
   toaq_pkg::cmd_type   cmd;

   logic                           req_fire;
   logic [toaq_pkg::STAMP_W-1:0]   act_time;
   logic [toaq_pkg::PAYLOAD_W-1:0] act_payload;
   logic [toaq_pkg::STAMP_W-1:0]   now_time;
   logic                           is_full;
   logic                           is_empty;
   logic                           head_due;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [toaq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [toaq_pkg::STAMP_W-1:0]     rel_time_ff, rel_time_in;
   logic [toaq_pkg::PAYLOAD_W-1:0]   rel_payload_ff, rel_payload_in;
   logic [toaq_pkg::STAMP_W-1:0]     next_time_ff, next_time_in;
   logic                             next_valid_ff, next_valid_in;

   assign act_time    = req_tdata[31:0];
   assign act_payload = req_tdata[63:32];
   assign now_time    = req_tdata[95:64];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_full  = cell_entry[QUEUE_DEPTH-1].valid;
   assign is_empty = !cell_entry[0].valid;
   assign head_due = cell_entry[0].stamp <= now_time;

   // one command to all cells; refused pushes and pops leave the chain alone
   always_comb begin
      cmd.stamp   = act_time;
      cmd.payload = act_payload;
      cmd.op      = toaq_pkg::OP_HOLD;
      if (req_fire) begin
         if (req_tuser == toaq_pkg::KIND_PUSH) begin
            if (!is_full) begin
               cmd.op = toaq_pkg::OP_PUSH;
            end
         end else if (!is_empty && head_due) begin
            cmd.op = toaq_pkg::OP_POP;
         end
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      toaq_pkg::entry_type prev_entry;
      toaq_pkg::entry_type next_entry;
      logic                prev_later;

      if (i == 0) begin : g_head
         assign prev_entry = toaq_pkg::EMPTY_ENTRY;
         assign prev_later = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_later = cell_later[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry = toaq_pkg::EMPTY_ENTRY;
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      toaq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_later (prev_later),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .later      (cell_later[i]),
         .entry      (cell_entry[i])
      );
   end

   // response for the accepted request, built from the chain before it moves
   always_comb begin
      status_in      = toaq_pkg::STATUS_OK;
      rel_time_in    = '0;
      rel_payload_in = '0;
      next_time_in   = '0;
      next_valid_in  = 1'b0;
      if (req_tuser == toaq_pkg::KIND_PUSH) begin
         status_in = is_full ? toaq_pkg::STATUS_FULL : toaq_pkg::STATUS_OK;
      end else if (is_empty) begin
         status_in = toaq_pkg::STATUS_EMPTY;
      end else if (!head_due) begin
         status_in     = toaq_pkg::STATUS_NOT_DUE;
         next_time_in  = cell_entry[0].stamp;
         next_valid_in = 1'b1;
      end else begin
         rel_time_in    = cell_entry[0].stamp;
         rel_payload_in = cell_entry[0].payload;
         next_valid_in  = cell_entry[1].valid;
         next_time_in   = cell_entry[1].valid ? cell_entry[1].stamp : '0;
      end
   end

   always_comb begin
      priority if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff      <= status_in;
         rel_time_ff    <= rel_time_in;
         rel_payload_ff <= rel_payload_in;
         next_time_ff   <= next_time_in;
         next_valid_ff  <= next_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'b0, next_valid_ff, next_time_ff, rel_payload_ff, rel_time_ff};

endmodule

`default_nettype wire

// ===== rtl/core/toaq_checker.sv =====
// Port-level checks of the time ordered activity queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module toaq_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   `TOAQ_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "response valid right after reset")

   `TOAQ_ASSERT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   `TOAQ_ASSERT(a_ready_when_free, clock, reset, !rsp_tvalid |-> req_tready, "request refused with no pending response")

   `TOAQ_ASSERT(a_empty_clean, clock, reset, rsp_tvalid && rsp_tuser == toaq_pkg::STATUS_EMPTY |-> rsp_tdata == '0, "empty response carries data")

   `TOAQ_ASSERT(a_not_due_next, clock, reset, rsp_tvalid && rsp_tuser == toaq_pkg::STATUS_NOT_DUE |-> rsp_tdata[96] && rsp_tdata[63:0] == '0, "not-due response malformed")

endmodule

bind time_ordered_activity_queue toaq_checker u_toaq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== tb/time_ordered_activity_queue_test.sv =====
// Self-checking testbench of the time ordered activity queue: streamed requests, checked responses.
`default_nettype none

module time_ordered_activity_queue_test;

   localparam int QUEUE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int IDLE_LIMIT     = 5000;  // cycles with no handshake before giving up
   localparam int HOLDOFF_AFTER  = 600;   // requests accepted before the long receiver stall
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 10;    // quiet cycles after the last response

   // One request as queued for the driver. hold_for_drain makes the driver wait
   // until every response owed so far has come back before offering it.
   typedef struct {
      logic                           kind;
      logic [toaq_pkg::STAMP_W-1:0]   activity_time;
      logic [toaq_pkg::PAYLOAD_W-1:0] activity_payload;
      logic [toaq_pkg::STAMP_W-1:0]   now_time;
      bit                             hold_for_drain;
   } request_type;

   // One stored activity of the local copy of the queue.
   typedef struct {
      logic [toaq_pkg::STAMP_W-1:0]   stamp;
      logic [toaq_pkg::PAYLOAD_W-1:0] payload;
   } activity_type;

   // What the block must answer for one request.
   typedef struct packed {
      logic [toaq_pkg::STATUS_W-1:0]  status;
      logic [toaq_pkg::STAMP_W-1:0]   released_time;
      logic [toaq_pkg::PAYLOAD_W-1:0] released_payload;
      logic [toaq_pkg::STAMP_W-1:0]   next_time;
      logic                           next_valid;
   } outcome_type;

   // Receiver back-pressure patterns.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   request_type  stim_q[$];      // requests not yet accepted, head is on the bus
   activity_type timeline_q[$];  // local copy of the stored activities, earliest first
   outcome_type  outcome_q[$];   // responses owed by the block, oldest first

   bit  req_taken      = 1'b0;  // head request was accepted at the last rising edge
   int  accepted_count = 0;
   int  rsp_count      = 0;
   int  error_count    = 0;
   int  idle_cycles    = 0;

   // sender burst state
   int  burst_left = 1;
   int  gap_left   = 0;

   // receiver state
   ready_mode_type ready_mode    = READY_ALWAYS;
   int             mode_left     = 0;
   int             holdoff_left  = 0;
   bit             holdoff_done  = 1'b0;
   int unsigned    ready_phase   = 0;

   time_ordered_activity_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Request builders. The fields a request kind ignores get random values.
   // ------------------------------------------------------------------------
   task automatic add_push(input logic [toaq_pkg::STAMP_W-1:0] stamp,
                           input logic [toaq_pkg::PAYLOAD_W-1:0] data,
                           input bit drain = 1'b0);
      request_type rq;
      rq.kind             = toaq_pkg::KIND_PUSH;
      rq.activity_time    = stamp;
      rq.activity_payload = data;
      rq.now_time         = $urandom;
      rq.hold_for_drain   = drain;
      stim_q.push_back(rq);
   endtask

   task automatic add_pop(input logic [toaq_pkg::STAMP_W-1:0] now, input bit drain = 1'b0);
      request_type rq;
      rq.kind             = toaq_pkg::KIND_POP;
      rq.activity_time    = $urandom;
      rq.activity_payload = $urandom;
      rq.now_time         = now;
      rq.hold_for_drain   = drain;
      stim_q.push_back(rq);
   endtask

   // ------------------------------------------------------------------------
   // Apply one accepted request to the local queue copy and return the
   // response the block owes for it.
   // ------------------------------------------------------------------------
   function automatic outcome_type queue_outcome(request_type rq);
      outcome_type  o;
      activity_type entry;
      int           pos;
      o = '0;
      if (rq.kind == toaq_pkg::KIND_PUSH) begin
         if (timeline_q.size() >= QUEUE_DEPTH) begin
            o.status = toaq_pkg::STATUS_FULL;
         end else begin
            // new entry goes behind every equal or earlier stamp
            pos = 0;
            while (pos < timeline_q.size() && timeline_q[pos].stamp <= rq.activity_time)
               pos++;
            entry.stamp   = rq.activity_time;
            entry.payload = rq.activity_payload;
            timeline_q.insert(pos, entry);
            o.status = toaq_pkg::STATUS_OK;
         end
      end else if (timeline_q.size() == 0) begin
         o.status = toaq_pkg::STATUS_EMPTY;
      end else if (timeline_q[0].stamp > rq.now_time) begin
         o.status     = toaq_pkg::STATUS_NOT_DUE;
         o.next_time  = timeline_q[0].stamp;
         o.next_valid = 1'b1;
      end else begin
         entry = timeline_q.pop_front();
         o.status           = toaq_pkg::STATUS_OK;
         o.released_time    = entry.stamp;
         o.released_payload = entry.payload;
         if (timeline_q.size() != 0) begin
            o.next_time  = timeline_q[0].stamp;
            o.next_valid = 1'b1;
         end
      end
      return o;
   endfunction

   // One line per mismatch, counted.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: response %0d, %s: got %h, want %h", rsp_count, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. The response is
   // checked before this edge's request is predicted, so a response that
   // arrives with nothing owed cannot be matched against the new request.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("response with no request owed", {30'd0, rsp_tuser}, '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", {30'd0, rsp_tuser}, {30'd0, want.status});
               if (rsp_tdata[31:0] !== want.released_time)
                  report_mismatch("released_time", rsp_tdata[31:0], want.released_time);
               if (rsp_tdata[63:32] !== want.released_payload)
                  report_mismatch("released_payload", rsp_tdata[63:32], want.released_payload);
               if (rsp_tdata[95:64] !== want.next_time)
                  report_mismatch("next_time", rsp_tdata[95:64], want.next_time);
               if (rsp_tdata[96] !== want.next_valid)
                  report_mismatch("next_valid", {31'd0, rsp_tdata[96]}, {31'd0, want.next_valid});
               if (rsp_tdata[103:97] !== 7'd0)
                  report_mismatch("tdata padding", {25'd0, rsp_tdata[103:97]}, '0);
            end
            rsp_count++;
         end
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(queue_outcome(stim_q[0]));
            void'(stim_q.pop_front());
            req_taken = 1'b1;
            accepted_count++;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // Driver: at the falling edge either hold an offered request that was not
   // taken, or start the next one. Bursts of random length alternate with
   // random gaps; some bursts run back to back with no gap at all.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (stim_q.size() != 0 &&
                      !(stim_q[0].hold_for_drain && outcome_q.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= stim_q[0].kind;
            req_tdata  <= {stim_q[0].now_time, stim_q[0].activity_payload,
                           stim_q[0].activity_time};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: rsp_tready follows a random pattern, redrawn after a random
   // stretch of cycles. Once, after enough requests, it holds off for a long
   // stretch so the block backs up and stalls the request side.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      ready_phase++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (!holdoff_done && accepted_count >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 128);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   rsp_tready <= ($urandom_range(0, 4) == 0);
            default:        rsp_tready <= (ready_phase[2:0] != 3'd0);
         endcase
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ------------------------------------------------------------------------
   initial begin
      int                           produced;
      int                           seg_len;
      int                           push_pct;
      int                           sel;
      bit                           drain;
      logic [toaq_pkg::STAMP_W-1:0] base;
      logic [toaq_pkg::STAMP_W-1:0] stamp;
      logic [toaq_pkg::STAMP_W-1:0] now;

      // Directed: empty pop, extreme stamps and payloads, release at now=0,
      // not-due pop, pop that empties the queue, then fill with ties up to
      // full and push into the full queue.
      add_pop('1);
      add_push('1, '1);
      add_push('0, '0);
      add_pop('0);
      add_pop(32'hFFFF_FFFE);
      add_pop('1);
      add_pop('0);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         add_push(32'd100 + ((i * 3) % 5), 32'hA500_0000 | i);
      add_push('0, 32'h5A5A_5A5A);
      add_pop(32'd102);

      // Random: segments with a push bias of their own, stamps clustered
      // around a moving base so ties and due/not-due pops are common, plus
      // full-range noise in every field.
      produced = 0;
      base     = 32'd1000;
      while (produced < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 80);
         case ($urandom_range(0, 4))
            0: push_pct = 5;
            1: push_pct = 20;
            2: push_pct = 50;
            3: push_pct = 80;
            default: push_pct = 95;
         endcase
         // first segment always waits for the directed part to drain
         drain = (produced == 0) || ($urandom_range(0, 7) == 0);
         base  = base + $urandom_range(0, 48);
         if ($urandom_range(0, 15) == 0)
            base = $urandom;
         for (int k = 0; k < seg_len; k++) begin
            if ($urandom_range(1, 100) <= push_pct) begin
               stamp = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 63);
               add_push(stamp, $urandom, drain && k == 0);
            end else begin
               sel = $urandom_range(0, 11);
               if (sel == 0)      now = '0;
               else if (sel == 1) now = '1;
               else if (sel == 2) now = $urandom;
               else               now = base + $urandom_range(0, 95) - 16;
               add_pop(now, drain && k == 0);
            end
            produced++;
         end
      end

      repeat (8) @(negedge clock);
      reset = 1'b0;

      wait (stim_q.size() == 0 && outcome_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch("responses never returned", '0, outcome_q.size());
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== time_ordered_activity_queue.f =====
+incdir+rtl/core
rtl/core/toaq_pkg.sv
rtl/core/toaq_cell.sv
rtl/core/time_ordered_activity_queue.sv
rtl/core/toaq_checker.sv
tb/time_ordered_activity_queue_test.sv
